FILE: hdl/matrix_inverse_4x4_top_defines.svh
// Assertion macros used by the matrix inverse controller.
`ifndef MATRIX_INVERSE_4X4_TOP_DEFINES_SVH
`define MATRIX_INVERSE_4X4_TOP_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define MI4_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mi4 same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define MI4_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mi4 next-cycle check failed");

`endif

FILE: hdl/mi4_pkg.sv
`timescale 1ns / 1ps

package mi4_pkg;

  localparam int MAT_N     = 4;
  localparam int ELEM_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int LIMB_W    = 32;
  localparam int Y_W       = 4 * LIMB_W;       // wide multiplicand, four limbs
  localparam int ACC_W     = 132;              // holds the determinant exactly
  localparam int COF_N     = MAT_N * MAT_N;
  localparam int QUO_W     = 2 * FRAC_BITS + 1;
  localparam int REM_W     = ACC_W + 1;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_col0;
    logic signed [ELEM_W-1:0] elem_col1;
    logic signed [ELEM_W-1:0] elem_col2;
    logic signed [ELEM_W-1:0] elem_col3;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] inv_col0;
    logic signed [ELEM_W-1:0] inv_col1;
    logic signed [ELEM_W-1:0] inv_col2;
    logic signed [ELEM_W-1:0] inv_col3;
    logic                     singular;
    logic                     saturated;
    logic                     last_row;
  } out_item_t;

  typedef enum logic [1:0] {Y_ELEM, Y_M2, Y_COF} ysel_t;
  typedef enum logic [1:0] {T_M2, T_C3, T_DET} tgt_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_FETCH, ST_MUL, ST_DRAIN, ST_STORE, ST_CHECK,
    ST_ROWBEG, ST_DLOAD, ST_DCHK, ST_DSTEP, ST_PUT, ST_PUSH
  } state_t;

  // One multiply-accumulate step of the cofactor or determinant sequence
  typedef struct packed {
    logic [1:0] row_a;
    logic [1:0] col_x;
    logic [1:0] row_b;
    logic [1:0] col_y;
    ysel_t      ysel;
    tgt_t       tgt;
    logic       clr;
    logic       sub;
    logic [1:0] nl;      // number of limbs minus one
  } op_t;

  typedef struct packed {
    logic       wr_en;
    logic [1:0] wr_row;
    logic       rd_en;
    op_t        op;
    logic       mul_en;
    logic [1:0] lc;
    logic       limb_top;
    logic [3:0] cof_addr;
    logic       cof_wr;
    logic       dvs_load;
    logic       div_load;
    logic       div_chk;
    logic       div_step;
    logic       put_en;
    logic [1:0] put_col;
    logic       row_clr;
    logic       row_push;
    logic       row_last;
  } cmd_t;

  typedef struct packed {
    logic det_zero;
    logic out_free;
  } sts_t;

  // Index k of the set {0..3} with one member dropped
  function automatic logic [1:0] skip_idx(input logic [1:0] k, input logic [1:0] drop);
    skip_idx = (k < drop) ? k : k + 2'd1;
  endfunction

  // Step of the 3x3 minor for cofactor cidx: 2x2 products, then the outer term
  function automatic op_t cof_op(input logic [3:0] cidx, input logic [1:0] term,
                                 input logic [1:0] phase);
    op_t        o;
    logic [1:0] ci;
    logic [1:0] cj;
    logic [1:0] p;
    logic [1:0] q;
    ci = cidx[3:2];
    cj = cidx[1:0];
    p  = skip_idx((term == 2'd0) ? 2'd1 : 2'd0, cj);
    q  = skip_idx((term == 2'd2) ? 2'd1 : 2'd2, cj);
    o  = '0;
    case (phase)
      2'd0: begin
        o.row_a = skip_idx(2'd1, ci);
        o.col_x = p;
        o.row_b = skip_idx(2'd2, ci);
        o.col_y = q;
        o.ysel  = Y_ELEM;
        o.tgt   = T_M2;
        o.clr   = 1'b1;
      end
      2'd1: begin
        o.row_a = skip_idx(2'd1, ci);
        o.col_x = q;
        o.row_b = skip_idx(2'd2, ci);
        o.col_y = p;
        o.ysel  = Y_ELEM;
        o.tgt   = T_M2;
        o.sub   = 1'b1;
      end
      default: begin
        o.row_a = skip_idx(2'd0, ci);
        o.col_x = skip_idx(term, cj);
        o.ysel  = Y_M2;
        o.tgt   = T_C3;
        o.clr   = (term == 2'd0);
        o.sub   = term[0] ^ ci[0] ^ cj[0];
        o.nl    = 2'd2;
      end
    endcase
    return o;
  endfunction

  // Step of the determinant expansion along row zero
  function automatic op_t det_op(input logic [1:0] didx);
    op_t o;
    o       = '0;
    o.col_x = didx;
    o.ysel  = Y_COF;
    o.tgt   = T_DET;
    o.clr   = (didx == 2'd0);
    o.nl    = 2'd3;
    return o;
  endfunction

endpackage

FILE: hdl/mi4_ctrl.sv
`timescale 1ns / 1ps
`include "matrix_inverse_4x4_top_defines.svh"

module mi4_ctrl import mi4_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic mat_valid,
  output logic mat_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t     state, state_next;
  logic [1:0] rows_loaded, rows_loaded_next;
  logic [3:0] cidx, cidx_next;
  logic [1:0] term, term_next;
  logic [1:0] phase, phase_next;
  logic       mode, mode_next;
  logic [1:0] didx, didx_next;
  logic [1:0] lc, lc_next;
  logic [1:0] orow, orow_next;
  logic [1:0] ocol, ocol_next;
  logic [5:0] dcnt, dcnt_next;
  op_t        op;

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      rows_loaded <= '0;
      cidx        <= '0;
      term        <= '0;
      phase       <= '0;
      mode        <= 1'b0;
      didx        <= '0;
      lc          <= '0;
      orow        <= '0;
      ocol        <= '0;
      dcnt        <= '0;
    end else begin
      state       <= state_next;
      rows_loaded <= rows_loaded_next;
      cidx        <= cidx_next;
      term        <= term_next;
      phase       <= phase_next;
      mode        <= mode_next;
      didx        <= didx_next;
      lc          <= lc_next;
      orow        <= orow_next;
      ocol        <= ocol_next;
      dcnt        <= dcnt_next;
    end
  end

  assign mat_stall = (state != ST_LOAD);

  // Decode the current arithmetic step
  always_comb begin
    op = mode ? det_op(didx) : cof_op(cidx, term, phase);
  end

  // Next state and commands
  always_comb begin
    state_next       = state;
    rows_loaded_next = rows_loaded;
    cidx_next        = cidx;
    term_next        = term;
    phase_next       = phase;
    mode_next        = mode;
    didx_next        = didx;
    lc_next          = lc;
    orow_next        = orow;
    ocol_next        = ocol;
    dcnt_next        = dcnt;

    cmd          = '0;
    cmd.op       = op;
    cmd.wr_row   = rows_loaded;
    cmd.lc       = lc;
    cmd.limb_top = (lc == op.nl);
    cmd.put_col  = ocol;
    cmd.row_last = (orow == 2'd3);
    if (state == ST_DLOAD) begin
      cmd.cof_addr = {ocol, orow};
    end else if (mode) begin
      cmd.cof_addr = {2'b00, didx};
    end else begin
      cmd.cof_addr = cidx;
    end

    case (state)
      ST_LOAD: begin
        if (mat_valid) begin
          cmd.wr_en = 1'b1;
          if (rows_loaded == 2'd3) begin
            rows_loaded_next = '0;
            cidx_next        = '0;
            term_next        = '0;
            phase_next       = '0;
            mode_next        = 1'b0;
            didx_next        = '0;
            state_next       = ST_FETCH;
          end else begin
            rows_loaded_next = rows_loaded + 2'd1;
          end
        end
      end
      ST_FETCH: begin
        cmd.rd_en  = 1'b1;
        lc_next    = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        if (lc == op.nl) begin
          if (!mode) begin
            if (phase != 2'd2) begin
              phase_next = phase + 2'd1;
              state_next = ST_FETCH;
            end else if (term != 2'd2) begin
              term_next  = term + 2'd1;
              phase_next = '0;
              state_next = ST_FETCH;
            end else begin
              state_next = ST_DRAIN;
            end
          end else if (didx != 2'd3) begin
            didx_next  = didx + 2'd1;
            state_next = ST_FETCH;
          end else begin
            state_next = ST_DRAIN;
          end
        end else begin
          lc_next = lc + 2'd1;
        end
      end
      ST_DRAIN: begin
        state_next = mode ? ST_CHECK : ST_STORE;
      end
      ST_STORE: begin
        cmd.cof_wr = 1'b1;
        term_next  = '0;
        phase_next = '0;
        if (cidx == 4'd15) begin
          mode_next = 1'b1;
          didx_next = '0;
        end else begin
          cidx_next = cidx + 4'd1;
        end
        state_next = ST_FETCH;
      end
      ST_CHECK: begin
        cmd.dvs_load = 1'b1;
        orow_next    = '0;
        state_next   = ST_ROWBEG;
      end
      ST_ROWBEG: begin
        cmd.row_clr = 1'b1;
        ocol_next   = '0;
        state_next  = sts.det_zero ? ST_PUSH : ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DCHK;
      end
      ST_DCHK: begin
        cmd.div_chk = 1'b1;
        dcnt_next   = '0;
        state_next  = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.div_step = 1'b1;
        if (dcnt == 6'(QUO_W - 1)) begin
          state_next = ST_PUT;
        end else begin
          dcnt_next = dcnt + 6'd1;
        end
      end
      ST_PUT: begin
        cmd.put_en = 1'b1;
        if (ocol == 2'd3) begin
          state_next = ST_PUSH;
        end else begin
          ocol_next  = ocol + 2'd1;
          state_next = ST_DLOAD;
        end
      end
      ST_PUSH: begin
        if (sts.out_free) begin
          cmd.row_push = 1'b1;
          if (orow == 2'd3) begin
            state_next = ST_LOAD;
          end else begin
            orow_next  = orow + 2'd1;
            state_next = ST_ROWBEG;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  `MI4_ASSERT_NEXT(a_start, clk, rst, (state == ST_LOAD && mat_valid && rows_loaded == 2'd3), (state == ST_FETCH && cidx == 4'd0 && !mode))
  `MI4_ASSERT_NOW(a_limb, clk, rst, (state == ST_MUL), (lc <= op.nl))
  `MI4_ASSERT_NOW(a_dcnt, clk, rst, (state == ST_DSTEP), (dcnt <= 6'(QUO_W - 1)))
  `MI4_ASSERT_NEXT(a_done, clk, rst, (cmd.row_push && cmd.row_last), (state == ST_LOAD))

endmodule

FILE: hdl/mi4_dp.sv
`timescale 1ns / 1ps

module mi4_dp import mi4_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  mat_row,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      inv_valid,
  input  logic      inv_stall,
  output out_item_t inv_row
);

  logic [Y_W-1:0]    mem [MAT_N];
  logic [Y_W-1:0]    rowa;
  logic [Y_W-1:0]    rowb;
  logic [Y_W-1:0]    cof [COF_N];
  logic [Y_W-1:0]    cof_q;
  logic [ELEM_W-1:0] xe;
  logic [ELEM_W-1:0] ye;
  logic [Y_W-1:0]    y;
  logic [LIMB_W-1:0] limb;
  logic signed [LIMB_W:0]     lx;
  logic signed [LIMB_W:0]     ly;
  logic signed [2*LIMB_W+1:0] prod;
  logic       p_vld;
  logic [1:0] p_lc;
  tgt_t       p_tgt;
  logic       p_clr;
  logic       p_sub;
  logic       p_first;
  logic [ACC_W-1:0] m2;
  logic [ACC_W-1:0] c3;
  logic [ACC_W-1:0] det;
  logic [ACC_W-1:0] sh;
  logic [ACC_W-1:0] base;
  logic [ACC_W-1:0] sum;
  logic             det_neg;
  logic [ACC_W-1:0] dmag;
  logic             cof_neg;
  logic [Y_W-1:0]   cmag;
  logic [ACC_W-1:0] dvs;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rs;
  logic [QUO_W-1:0] nlo;
  logic [QUO_W-1:0] q;
  logic             qneg;
  logic             ovf;
  logic             sat_e;
  logic [ELEM_W-1:0] val;
  logic [ELEM_W-1:0] rowbuf [MAT_N];
  logic              rsat;

  // Store one input row per item
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_row] <= {mat_row.elem_col3, mat_row.elem_col2,
                          mat_row.elem_col1, mat_row.elem_col0};
    end
    if (cmd.rd_en) begin
      rowa <= mem[cmd.op.row_a];
      rowb <= mem[cmd.op.row_b];
    end
  end

  // Select operands and the current limb
  always_comb begin
    cof_q = cof[cmd.cof_addr];
    xe    = rowa[{cmd.op.col_x, 5'd0} +: ELEM_W];
    ye    = rowb[{cmd.op.col_y, 5'd0} +: ELEM_W];
    case (cmd.op.ysel)
      Y_ELEM:  y = {{(Y_W - ELEM_W){ye[ELEM_W-1]}}, ye};
      Y_M2:    y = m2[Y_W-1:0];
      Y_COF:   y = cof_q;
      default: y = '0;
    endcase
    limb = y[{cmd.lc, 5'd0} +: LIMB_W];
    lx   = {xe[ELEM_W-1], xe};
    ly   = {cmd.limb_top & limb[LIMB_W-1], limb};
  end

  // Multiply one limb, registered before accumulation
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= cmd.mul_en;
    end
    prod    <= lx * ly;
    p_lc    <= cmd.lc;
    p_tgt   <= cmd.op.tgt;
    p_clr   <= cmd.op.clr;
    p_sub   <= cmd.op.sub;
    p_first <= (cmd.lc == 2'd0);
  end

  // Accumulate shifted partial products
  always_comb begin
    sh = ACC_W'(prod) << {p_lc, 5'd0};
    case (p_tgt)
      T_M2:    base = m2;
      T_C3:    base = c3;
      T_DET:   base = det;
      default: base = '0;
    endcase
    if (p_first && p_clr) begin
      base = '0;
    end
    sum = p_sub ? (base - sh) : (base + sh);
  end

  always_ff @(posedge clk) begin
    if (p_vld) begin
      case (p_tgt)
        T_M2:    m2  <= sum;
        T_C3:    c3  <= sum;
        T_DET:   det <= sum;
        default: m2  <= m2;
      endcase
    end
    if (cmd.cof_wr) begin
      cof[cmd.cof_addr] <= c3[Y_W-1:0];
    end
  end

  // Magnitudes and signs for the divider
  always_comb begin
    det_neg = det[ACC_W-1];
    dmag    = det_neg ? (~det + ACC_W'(1)) : det;
    cof_neg = cof_q[Y_W-1];
    cmag    = cof_neg ? (~cof_q + Y_W'(1)) : cof_q;
    rs      = {rem[REM_W-2:0], nlo[QUO_W-1]};
  end

  // Restoring division, one quotient bit a step
  always_ff @(posedge clk) begin
    if (cmd.dvs_load) begin
      dvs <= dmag;
    end
    if (cmd.div_load) begin
      rem  <= REM_W'(cmag[Y_W-1:1]);
      nlo  <= {cmag[0], {(2 * FRAC_BITS){1'b0}}};
      q    <= '0;
      qneg <= cof_neg ^ det_neg;
    end else if (cmd.div_chk) begin
      ovf <= (rem >= {1'b0, dvs});
    end else if (cmd.div_step) begin
      nlo <= {nlo[QUO_W-2:0], 1'b0};
      if (rs >= {1'b0, dvs}) begin
        rem <= rs - {1'b0, dvs};
        q   <= {q[QUO_W-2:0], 1'b1};
      end else begin
        rem <= rs;
        q   <= {q[QUO_W-2:0], 1'b0};
      end
    end
  end

  // Saturate the quotient to the output range
  always_comb begin
    sat_e = ovf || (qneg ? (q > QUO_W'(33'h0_8000_0000)) : (q > QUO_W'(33'h0_7FFF_FFFF)));
    if (sat_e) begin
      val = qneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      val = qneg ? (~q[ELEM_W-1:0] + 32'd1) : q[ELEM_W-1:0];
    end
  end

  // Collect a result row
  always_ff @(posedge clk) begin
    if (cmd.row_clr) begin
      for (int i = 0; i < MAT_N; i++) begin
        rowbuf[i] <= '0;
      end
      rsat <= 1'b0;
    end else if (cmd.put_en) begin
      rowbuf[cmd.put_col] <= val;
      rsat                <= rsat | sat_e;
    end
  end

  // Output register, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_valid <= 1'b0;
    end else if (cmd.row_push) begin
      inv_valid <= 1'b1;
    end else if (!inv_stall) begin
      inv_valid <= 1'b0;
    end
    if (cmd.row_push) begin
      inv_row.inv_col0  <= rowbuf[0];
      inv_row.inv_col1  <= rowbuf[1];
      inv_row.inv_col2  <= rowbuf[2];
      inv_row.inv_col3  <= rowbuf[3];
      inv_row.singular  <= sts.det_zero;
      inv_row.saturated <= rsat;
      inv_row.last_row  <= cmd.row_last;
    end
  end

  assign sts.det_zero = (det == '0);
  assign sts.out_free = !inv_valid || !inv_stall;

endmodule

FILE: hdl/matrix_inverse_4x4_top.sv
// Flow: after the fourth row item, all sixteen cofactors and then the determinant are
// computed, then each result row is divided out (a singular matrix skips the divider).
// Throughput: rows are taken one per cycle while mat_stall is low; after the fourth row it
// stays high until the last result row is pushed. The shared 33x33 multiplier and the one-bit-a-cycle divider set it.
// Reset: synchronous, active high; clears the row count and sequencer, drops inv_valid.
`timescale 1ns / 1ps

module matrix_inverse_4x4_top import mi4_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      mat_valid,
  output logic      mat_stall,
  input  in_item_t  mat_row,
  output logic      inv_valid,
  input  logic      inv_stall,
  output out_item_t inv_row
);

  cmd_t cmd;
  sts_t sts;

  mi4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .mat_valid (mat_valid),
    .mat_stall (mat_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mi4_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .mat_row   (mat_row),
    .cmd       (cmd),
    .sts       (sts),
    .inv_valid (inv_valid),
    .inv_stall (inv_stall),
    .inv_row   (inv_row)
  );

endmodule
